// ----- sv/pfhd_pkg.sv -----
// Shared types and codes for the protobuf field header decoder.
`default_nettype none

package pfhd_pkg;

  // Parser limit on base-128 groups per varint
  localparam int unsigned MAX_GROUPS = 10;

  // Mode register codes
  localparam logic [1:0] MODE_FIELD = 2'd0;
  localparam logic [1:0] MODE_WRAP  = 2'd1;
  localparam logic [1:0] MODE_V32   = 2'd2;
  localparam logic [1:0] MODE_V64   = 2'd3;

  // Parser phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_VARINT = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERRUN  = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;

  // Supported wire types
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_FIXED  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_t;

  typedef struct packed {
    logic [28:0] tag;
    logic [2:0]  wtype;
    logic [15:0] string_length;
    logic [63:0] value;
    logic [3:0]  bytes_used;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  group_index;
    logic [63:0] accumulator;
    logic        overflow_seen;
    logic [28:0] held_tag;
    logic [2:0]  held_wtype;
    logic [3:0]  byte_count;
  } state_t;

endpackage

`default_nettype wire

// ----- sv/protobuf_field_header_decoder.sv -----
// Top level: byte-stream protobuf varint and field header decoder.
// A result is registered and shows in the cycle after the byte that completes it.
// Throughput: one byte per cycle; a byte is taken while a result waits, as
// long as the output register is free or being drained that same cycle.
// Reset: mode returns to field header, the parser goes idle, no result pending.
`default_nettype none

module protobuf_field_header_decoder
  import pfhd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data
);

  logic [1:0] mode;
  state_t     state;
  state_t     state_next;
  logic       step_emit;
  out_t       step_res;
  logic       in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  pfhd_step u_step (
    .mode (mode),
    .cur  (state),
    .item (in_data),
    .nxt  (state_next),
    .emit (step_emit),
    .res  (step_res)
  );

  // mode register and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_FIELD;
      state <= '0;
    end else if (cfg_we) begin
      mode        <= cfg_wdata;
      state.phase <= PH_IDLE;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // result register: set on a new result, hold until drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (in_fire && step_emit) || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && step_emit) begin
      out_data <= step_res;
    end
  end

  // a byte flagged as buffer end always closes the item
  assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.buffer_end && !cfg_we |=> state.phase == PH_IDLE)
    else $error("buffer end left parser mid-item");

  // a closing byte always produces a transaction
  assert property (@(posedge clk) disable iff (rst)
    in_fire && step_emit |=> out_valid)
    else $error("result lost");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bytes_used != 4'd0 && out_data.status <= ST_BAD_TYPE)
    else $error("bad result bookkeeping");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.string_length == 16'd0 && out_data.value == 64'd0)
    else $error("error result carries payload");

  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

endmodule

`default_nettype wire

// ----- sv/pfhd_step.sv -----
// Per-byte varint parse step: next parser state and the result, if any.
`default_nettype none

module pfhd_step
  import pfhd_pkg::*;
(
  input  wire logic [1:0] mode,
  input  wire state_t     cur,
  input  wire in_t        item,
  output state_t          nxt,
  output logic            emit,
  output out_t            res
);

  logic        header;
  logic        first_short;
  logic        wide;
  logic [6:0]  grp;
  logic [3:0]  g;
  logic [6:0]  shamt;
  logic [63:0] acc_or;
  logic        ovf_new;
  logic [3:0]  bc_inc;
  logic [2:0]  wt;
  logic [28:0] t;
  logic        wt_ok;

  assign header = (mode == MODE_FIELD) || (mode == MODE_WRAP);
  assign grp    = item.data_byte[6:0];

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    res  = '0;

    // start a new item on the first byte
    if (cur.phase == PH_IDLE) begin
      nxt.phase         = PH_VARINT;
      nxt.group_index   = '0;
      nxt.accumulator   = '0;
      nxt.overflow_seen = 1'b0;
      nxt.byte_count    = '0;
    end

    first_short = (cur.phase == PH_IDLE) && header && item.buffer_end;
    g       = nxt.group_index;
    shamt   = 7'(g) * 7'd7;
    acc_or  = nxt.accumulator | (64'(grp) << shamt);
    bc_inc  = (nxt.byte_count != 4'hF) ? nxt.byte_count + 4'd1 : nxt.byte_count;
    wide    = (mode == MODE_V64) && (nxt.phase == PH_VARINT);
    ovf_new = nxt.overflow_seen |
              (!wide && (((g == 4'd4) && (grp >= 7'd16)) ||
                         ((g > 4'd4) && (grp != 7'd0))));
    wt      = acc_or[2:0];
    t       = acc_or[31:3];
    wt_ok   = (wt == WT_VARINT) || (wt == WT_LEN) || (wt == WT_FIXED);

    if (first_short) begin
      // a buffer that ends on the first header byte is an overrun
      nxt.byte_count = 4'd1;
      emit       = 1'b1;
      res.status = ST_OVERRUN;
    end else begin
      nxt.byte_count    = bc_inc;
      nxt.accumulator   = acc_or;
      nxt.overflow_seen = ovf_new;
      if (item.data_byte[7]) begin
        // continuation: advance the group or flag overrun
        if ((g >= 4'(MAX_GROUPS - 1)) || item.buffer_end) begin
          emit       = 1'b1;
          res.status = ST_OVERRUN;
        end else begin
          nxt.group_index = g + 4'd1;
        end
      end else if (ovf_new) begin
        emit       = 1'b1;
        res.status = ST_OVERRUN;
      end else if (!header) begin
        emit      = 1'b1;
        res.value = acc_or;
      end else if (nxt.phase == PH_LENGTH) begin
        emit              = 1'b1;
        res.tag           = cur.held_tag;
        res.wtype         = cur.held_wtype;
        res.string_length = acc_or[15:0];
      end else if (!wt_ok || ((mode == MODE_WRAP) && (wt != WT_LEN))) begin
        emit       = 1'b1;
        res.tag    = t;
        res.wtype  = wt;
        res.status = ST_BAD_TYPE;
      end else if (wt == WT_LEN) begin
        if (item.buffer_end) begin
          emit       = 1'b1;
          res.status = ST_OVERRUN;
        end else begin
          // hold the header and read the length varint
          nxt.held_tag      = t;
          nxt.held_wtype    = wt;
          nxt.phase         = PH_LENGTH;
          nxt.group_index   = '0;
          nxt.accumulator   = '0;
          nxt.overflow_seen = 1'b0;
        end
      end else begin
        emit      = 1'b1;
        res.tag   = t;
        res.wtype = wt;
      end
    end

    // drop back to idle after any result
    if (emit) begin
      nxt.phase = PH_IDLE;
    end
    res.bytes_used = nxt.byte_count;
  end

endmodule

`default_nettype wire
